// ===== sv/jbt_pkg.sv =====
// ----------------------------------------------------------------------------
// jbt_pkg: shared types and constants of the JSON byte tokenizer
// Item structs, event codes, lexer modes and the keyword letter tables.
// ----------------------------------------------------------------------------
package jbt_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [4:0] {
		EV_CURLY_OPEN   = 5'd0,
		EV_CURLY_CLOSE  = 5'd1,
		EV_ARRAY_OPEN   = 5'd2,
		EV_ARRAY_CLOSE  = 5'd3,
		EV_COLON        = 5'd4,
		EV_COMMA        = 5'd5,
		EV_STR_START    = 5'd6,
		EV_STR_BYTE     = 5'd7,
		EV_STR_END      = 5'd8,
		EV_NUM_BYTE     = 5'd9,
		EV_NUM_END      = 5'd10,
		EV_FALSE        = 5'd11,
		EV_TRUE         = 5'd12,
		EV_NULL         = 5'd13,
		EV_MISMATCH     = 5'd14,
		EV_UNTERMINATED = 5'd15,
		EV_UNRECOGNIZED = 5'd16,
		EV_STREAM_END   = 5'd17
	} event_kind_t;

	typedef enum logic [3:0] {
		MODE_IDLE    = 4'b0001,
		MODE_STRING  = 4'b0010,
		MODE_NUMBER  = 4'b0100,
		MODE_KEYWORD = 4'b1000
	} lex_mode_t;

	localparam logic [1:0] KW_FALSE = 2'd0;
	localparam logic [1:0] KW_TRUE  = 2'd1;
	localparam logic [1:0] KW_NULL  = 2'd2;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_marker;
	} in_item_t;

	typedef struct packed {
		event_kind_t event_kind;
		logic [7:0]  value_byte;
		logic        last_of_run;
	} out_item_t;

	// Results of one input item on their way into the output queue.
	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} push_t;

	function automatic logic [2:0] kw_length(input logic [1:0] sel);
		case (sel)
			KW_FALSE: kw_length = 3'd5;
			KW_TRUE:  kw_length = 3'd4;
			KW_NULL:  kw_length = 3'd4;
			default:  kw_length = 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] kw_letter(input logic [1:0] sel, input logic [2:0] pos);
		kw_letter = 8'h00;
		case (sel)
			KW_FALSE: begin
				case (pos)
					3'd0:    kw_letter = "f";
					3'd1:    kw_letter = "a";
					3'd2:    kw_letter = "l";
					3'd3:    kw_letter = "s";
					3'd4:    kw_letter = "e";
					default: kw_letter = 8'h00;
				endcase
			end
			KW_TRUE: begin
				case (pos)
					3'd0:    kw_letter = "t";
					3'd1:    kw_letter = "r";
					3'd2:    kw_letter = "u";
					3'd3:    kw_letter = "e";
					default: kw_letter = 8'h00;
				endcase
			end
			KW_NULL: begin
				case (pos)
					3'd0:    kw_letter = "n";
					3'd1:    kw_letter = "u";
					3'd2:    kw_letter = "l";
					3'd3:    kw_letter = "l";
					default: kw_letter = 8'h00;
				endcase
			end
			default: kw_letter = 8'h00;
		endcase
	endfunction

	function automatic event_kind_t kw_event(input logic [1:0] sel);
		case (sel)
			KW_FALSE: kw_event = EV_FALSE;
			KW_TRUE:  kw_event = EV_TRUE;
			KW_NULL:  kw_event = EV_NULL;
			default:  kw_event = EV_MISMATCH;
		endcase
	endfunction

endpackage

// ===== sv/jbt_lexer.sv =====
// ----------------------------------------------------------------------------
// jbt_lexer: lexer state and per-byte decode
// Holds the mode and keyword tracking and turns one registered item into
// up to two result items per cycle while advance is high.
// ----------------------------------------------------------------------------
module jbt_lexer import jbt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     advance,
	input  in_item_t item_s1,
	output push_t    push
);

	typedef struct packed {
		logic        hit;
		event_kind_t kind;
		logic [7:0]  val;
	} res_t;

	typedef struct packed {
		res_t       res;
		lex_mode_t  mode;
		logic       kw;
		logic [1:0] sel;
	} idle_t;

	lex_mode_t  mode_q, mode_d;
	logic [1:0] sel_q, sel_d;
	logic [2:0] pos_q, pos_d;
	res_t       res0, res1;
	idle_t      id;
	logic [7:0] c;

	// Decode of a byte seen between tokens.
	function automatic idle_t idle_decode(input logic [7:0] b);
		idle_t r;
		r = '{res: '{hit: 1'b1, kind: EV_UNRECOGNIZED, val: 8'h00},
		      mode: MODE_IDLE, kw: 1'b0, sel: KW_FALSE};
		case (b) inside
			" ", 8'h0A: r.res.hit = 1'b0;
			"{":        r.res.kind = EV_CURLY_OPEN;
			"}":        r.res.kind = EV_CURLY_CLOSE;
			"[":        r.res.kind = EV_ARRAY_OPEN;
			"]":        r.res.kind = EV_ARRAY_CLOSE;
			":":        r.res.kind = EV_COLON;
			",":        r.res.kind = EV_COMMA;
			CH_QUOTE: begin
				r.res.kind = EV_STR_START;
				r.mode     = MODE_STRING;
			end
			"f", "t", "n": begin
				r.res.hit = 1'b0;
				r.mode    = MODE_KEYWORD;
				r.kw      = 1'b1;
				r.sel     = (b == "f") ? KW_FALSE : ((b == "t") ? KW_TRUE : KW_NULL);
			end
			CH_MINUS, ["0":"9"]: begin
				r.res.kind = EV_NUM_BYTE;
				r.res.val  = b;
				r.mode     = MODE_NUMBER;
			end
			default: r.res.kind = EV_UNRECOGNIZED;
		endcase
		return r;
	endfunction

	assign c  = item_s1.text_byte;
	assign id = idle_decode(c);

	always_comb begin
		res0   = '0;
		res1   = '0;
		mode_d = mode_q;
		sel_d  = sel_q;
		pos_d  = pos_q;
		if (item_s1.end_marker) begin
			res0.hit = 1'b1;
			res1.hit = 1'b1;
			res1.kind = EV_STREAM_END;
			if (mode_q == MODE_NUMBER) begin
				res0.kind = EV_NUM_END;
			end else if (mode_q == MODE_STRING || mode_q == MODE_KEYWORD) begin
				res0.kind = EV_UNTERMINATED;
			end else begin
				res0.kind = EV_STREAM_END;
				res1.hit  = 1'b0;
			end
			mode_d = MODE_IDLE;
			sel_d  = KW_FALSE;
			pos_d  = 3'd0;
		end else begin
			case (mode_q)
				MODE_STRING: begin
					res0.hit = 1'b1;
					if (c == CH_QUOTE) begin
						res0.kind = EV_STR_END;
						mode_d    = MODE_IDLE;
					end else begin
						res0.kind = EV_STR_BYTE;
						res0.val  = c;
					end
				end
				MODE_NUMBER: begin
					res0.hit = 1'b1;
					if (c == CH_MINUS || c == CH_DOT || c inside {["0":"9"]}) begin
						res0.kind = EV_NUM_BYTE;
						res0.val  = c;
					end else begin
						// The closing byte is handled again as if between tokens.
						res0.kind = EV_NUM_END;
						res1      = id.res;
						mode_d    = id.mode;
						if (id.kw) begin
							sel_d = id.sel;
							pos_d = 3'd1;
						end
					end
				end
				MODE_KEYWORD: begin
					res0.hit = 1'b1;
					if (pos_q < kw_length(sel_q) && kw_letter(sel_q, pos_q) == c) begin
						if (pos_q + 3'd1 >= kw_length(sel_q)) begin
							res0.kind = kw_event(sel_q);
							mode_d    = MODE_IDLE;
							pos_d     = 3'd0;
						end else begin
							res0.hit = 1'b0;
							pos_d    = pos_q + 3'd1;
						end
					end else begin
						res0.kind = EV_MISMATCH;
						mode_d    = MODE_IDLE;
						pos_d     = 3'd0;
					end
				end
				default: begin
					res0   = id.res;
					mode_d = id.mode;
					if (id.kw) begin
						sel_d = id.sel;
						pos_d = 3'd1;
					end
				end
			endcase
		end
	end

	// A second result only ever follows a first one.
	always_comb begin
		push.count  = {1'b0, res0.hit} + {1'b0, res1.hit};
		push.first  = '{event_kind: res0.kind, value_byte: res0.val, last_of_run: !res1.hit};
		push.second = '{event_kind: res1.kind, value_byte: res1.val, last_of_run: 1'b1};
		if (!advance) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			sel_q  <= KW_FALSE;
			pos_q  <= 3'd0;
		end else if (advance) begin
			mode_q <= mode_d;
			sel_q  <= sel_d;
			pos_q  <= pos_d;
		end
	end

endmodule

// ===== sv/jbt_out_fifo.sv =====
// ----------------------------------------------------------------------------
// jbt_out_fifo: result queue
// Takes up to two result items per cycle and hands out one per cycle while event_stall is low.
// ----------------------------------------------------------------------------
module jbt_out_fifo import jbt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  push_t              push,
	output logic               room,
	output logic [FIFO_CW-1:0] level,
	output logic               event_valid,
	input  logic               event_stall,
	output out_item_t          event_item
);

	out_item_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               pop;

	assign level       = count_q;
	assign event_valid = (count_q != '0);
	assign event_item  = mem_q[rd_ptr_q];
	assign pop         = event_valid && !event_stall;
	// Room for two more items, judged from the registered fill level alone.
	assign room        = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + FIFO_AW'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + FIFO_CW'(push.count) - FIFO_CW'(pop);
		end
	end

endmodule

// ===== sv/json_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// json_byte_tokenizer: byte-serial JSON lexer
// Each input item is one text byte or an end-of-input marker; each output
// item is one token event with an optional byte and a last-of-run flag.
// ----------------------------------------------------------------------------
// Usage:
//   byte_valid/byte_stall/byte_item carry input items; event_valid/
//   event_stall/event_item carry result items. An item moves on a rising
//   edge where valid is high and stall is low.
//   An accepted byte is held in an input register while the lexer decodes
//   it against the current mode, and its results enter a four-entry queue.
//   The first result is offered from the queue once it is written there.
//   One byte is accepted per cycle as long as the queue holds at most two
//   items; an item gives zero, one or two results, and the output side
//   sends one per cycle while unstalled, so the sustained rate is one item
//   per cycle unless results outnumber input items or the receiver stalls.
//   When the receiver stalls, the queue fills and byte_stall rises while
//   the input register is held; nothing is dropped.
//   Reset empties the input register and the queue and puts the lexer in
//   its idle mode between tokens.
// ----------------------------------------------------------------------------
module json_byte_tokenizer import jbt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_item,
	output logic      event_valid,
	input  logic      event_stall,
	output out_item_t event_item
);

	in_item_t           item_s1;
	logic               valid_s1;
	logic               room;
	logic               advance;
	logic               accept;
	logic [FIFO_CW-1:0] level;
	push_t              push;

	assign advance    = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_item;
		end
	end

	jbt_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.push    (push)
	);

	jbt_out_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.room        (room),
		.level       (level),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_item  (event_item)
	);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.end_marker |=> event_valid)
		else $error("end of input produced no result");

	a_stream_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_item.event_kind == EV_STREAM_END |-> event_item.last_of_run)
		else $error("stream end not marked last of run");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |=> valid_s1)
		else $error("input register emptied while stalled");

endmodule

// ===== verif/json_byte_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// json_byte_tokenizer_tb: self-checking bench for the byte-serial JSON lexer
// Drives JSON text and end markers through the input channel and predicts
// every token event from an independent model of the lexer modes. Events
// are checked field by field as they leave the block. Both sides idle and
// stall at random, and one long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------
module json_byte_tokenizer_tb;
	import jbt_pkg::*;

	// Tracks the lexer state and holds the token events still to come.
	class token_tracker;
		lex_mode_t   mode;
		logic [1:0]  kw_sel;
		int unsigned kw_pos;
		string       kw_word[3];
		event_kind_t kw_done[3];
		out_item_t   run_q[$];
		out_item_t   expected_events[$];
		int unsigned errors;

		function new();
			kw_word = '{"false", "true", "null"};
			kw_done = '{EV_FALSE, EV_TRUE, EV_NULL};
			errors  = 0;
			clear_state();
		endfunction

		function void clear_state();
			mode   = MODE_IDLE;
			kw_sel = KW_FALSE;
			kw_pos = 0;
		endfunction

		function void flag(string what);
			errors++;
			$display("%0t: %s", $time, what);
		endfunction

		function void emit(event_kind_t kind, logic [7:0] value);
			out_item_t r;
			r.event_kind  = kind;
			r.value_byte  = value;
			r.last_of_run = 1'b0;
			run_q.push_back(r);
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		// A byte seen between tokens.
		function void lex_idle(logic [7:0] c);
			case (c)
				" ", 8'h0A: ;
				"{": emit(EV_CURLY_OPEN, 8'h00);
				"}": emit(EV_CURLY_CLOSE, 8'h00);
				"[": emit(EV_ARRAY_OPEN, 8'h00);
				"]": emit(EV_ARRAY_CLOSE, 8'h00);
				":": emit(EV_COLON, 8'h00);
				",": emit(EV_COMMA, 8'h00);
				CH_QUOTE: begin
					emit(EV_STR_START, 8'h00);
					mode = MODE_STRING;
				end
				"f", "t", "n": begin
					kw_sel = (c == "f") ? KW_FALSE : ((c == "t") ? KW_TRUE : KW_NULL);
					kw_pos = 1;
					mode   = MODE_KEYWORD;
				end
				default: begin
					if (c == CH_MINUS || is_digit(c)) begin
						emit(EV_NUM_BYTE, c);
						mode = MODE_NUMBER;
					end else begin
						emit(EV_UNRECOGNIZED, 8'h00);
					end
				end
			endcase
		endfunction

		function void note_byte(in_item_t it);
			logic [7:0] c;
			c = it.text_byte;
			run_q.delete();
			if (it.end_marker) begin
				if (mode == MODE_NUMBER) begin
					emit(EV_NUM_END, 8'h00);
				end else if (mode != MODE_IDLE) begin
					emit(EV_UNTERMINATED, 8'h00);
				end
				emit(EV_STREAM_END, 8'h00);
				clear_state();
			end else begin
				case (mode)
					MODE_STRING: begin
						if (c == CH_QUOTE) begin
							emit(EV_STR_END, 8'h00);
							mode = MODE_IDLE;
						end else begin
							emit(EV_STR_BYTE, c);
						end
					end
					MODE_NUMBER: begin
						if (c == CH_MINUS || c == CH_DOT || is_digit(c)) begin
							emit(EV_NUM_BYTE, c);
						end else begin
							emit(EV_NUM_END, 8'h00);
							mode = MODE_IDLE;
							lex_idle(c);
						end
					end
					MODE_KEYWORD: begin
						if (kw_pos < kw_word[kw_sel].len() && kw_word[kw_sel][kw_pos] == c) begin
							kw_pos++;
							if (kw_pos >= kw_word[kw_sel].len()) begin
								emit(kw_done[kw_sel], 8'h00);
								mode   = MODE_IDLE;
								kw_pos = 0;
							end
						end else begin
							// The mismatching byte is consumed, not handled again.
							emit(EV_MISMATCH, 8'h00);
							mode   = MODE_IDLE;
							kw_pos = 0;
						end
					end
					default: lex_idle(c);
				endcase
			end
			if (run_q.size() != 0) begin
				run_q[run_q.size() - 1].last_of_run = 1'b1;
			end
			foreach (run_q[i]) begin
				expected_events.push_back(run_q[i]);
			end
		endfunction

		function void check_event(out_item_t got);
			out_item_t want;
			if (expected_events.size() == 0) begin
				flag($sformatf("unexpected event: kind %0d value %02h last %0b",
					got.event_kind, got.value_byte, got.last_of_run));
				return;
			end
			want = expected_events.pop_front();
			if (got.event_kind !== want.event_kind) begin
				flag($sformatf("event_kind: expected %0d, got %0d",
					want.event_kind, got.event_kind));
			end
			if (got.value_byte !== want.value_byte) begin
				flag($sformatf("value_byte: expected %02h, got %02h",
					want.value_byte, got.value_byte));
			end
			if (got.last_of_run !== want.last_of_run) begin
				flag($sformatf("last_of_run: expected %0b, got %0b",
					want.last_of_run, got.last_of_run));
			end
		endfunction

		function void close_out();
			if (expected_events.size() != 0) begin
				flag($sformatf("%0d expected events never arrived",
					expected_events.size()));
			end
		endfunction
	endclass

	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      byte_valid  = 1'b0;
	logic      byte_stall;
	in_item_t  byte_item   = '0;
	logic      event_valid;
	logic      event_stall = 1'b0;
	out_item_t event_item;

	token_tracker tracker;
	in_item_t     byte_plan[$];
	bit           tx_gaps;
	bit           rx_quiet;
	int unsigned  hold_request;

	json_byte_tokenizer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_item   (byte_item),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_item  (event_item)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic void add_byte(logic [7:0] b);
		in_item_t it;
		it.text_byte  = b;
		it.end_marker = 1'b0;
		byte_plan.push_back(it);
	endfunction

	function automatic void add_end(logic [7:0] junk);
		in_item_t it;
		it.text_byte  = junk;
		it.end_marker = 1'b1;
		byte_plan.push_back(it);
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			add_byte(s[i]);
		end
	endfunction

	function automatic void add_string_body(int unsigned len);
		logic [7:0] b;
		for (int unsigned i = 0; i < len; i++) begin
			do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
			add_byte(b);
		end
	endfunction

	function automatic void add_number_tail(int unsigned len);
		int unsigned r;
		for (int unsigned i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				add_byte(8'("0" + $urandom_range(0, 9)));
			end else if (r < 85) begin
				add_byte(CH_DOT);
			end else begin
				add_byte(CH_MINUS);
			end
		end
	endfunction

	function automatic void add_keyword_prefix(int unsigned k, int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			add_byte(tracker.kw_word[k][i]);
		end
	endfunction

	// One token of mostly well-formed JSON text; the rest is noise, broken
	// keywords and end markers, some of them inside an open token.
	function automatic void add_token();
		string       punct;
		int unsigned r;
		int unsigned k;
		punct = "{}[]:,";
		r     = $urandom_range(0, 99);
		if (r < 18) begin
			add_byte(punct[$urandom_range(0, 5)]);
		end else if (r < 24) begin
			repeat ($urandom_range(1, 3)) add_byte($urandom_range(0, 1) ? " " : 8'h0A);
		end else if (r < 42) begin
			add_byte(CH_QUOTE);
			add_string_body(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
				: $urandom_range(0, 8));
			add_byte(CH_QUOTE);
		end else if (r < 58) begin
			add_byte($urandom_range(0, 3) == 0 ? CH_MINUS
				: 8'("0" + $urandom_range(0, 9)));
			add_number_tail($urandom_range(0, 6));
		end else if (r < 72) begin
			add_text(tracker.kw_word[$urandom_range(0, 2)]);
		end else if (r < 78) begin
			k = $urandom_range(0, 2);
			add_keyword_prefix(k, $urandom_range(1, tracker.kw_word[k].len() - 1));
			add_byte(8'($urandom_range(0, 255)));
		end else if (r < 84) begin
			case ($urandom_range(0, 3))
				0: begin
					add_byte(CH_QUOTE);
					add_string_body($urandom_range(0, 3));
				end
				1: begin
					k = $urandom_range(0, 2);
					add_keyword_prefix(k, $urandom_range(1, tracker.kw_word[k].len() - 1));
				end
				2: add_number_tail($urandom_range(1, 3));
				default: ;
			endcase
			add_end(8'($urandom_range(0, 255)));
		end else begin
			add_byte(8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic send_item(in_item_t it);
		int unsigned gap;
		gap = (tx_gaps && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= it;
		do @(posedge clk); while (byte_stall);
		tracker.note_byte(it);
	endtask

	task automatic send_plan();
		while (byte_plan.size() != 0) begin
			send_item(byte_plan.pop_front());
		end
	endtask

	// Stops offering items until every predicted event has come out.
	task automatic drain();
		byte_valid <= 1'b0;
		do @(posedge clk); while (tracker.expected_events.size() != 0);
	endtask

	initial begin : result_sink
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				event_stall <= 1'b1;
				hold_left--;
			end else if (rx_quiet || $urandom_range(0, 99) < 70) begin
				event_stall <= 1'b0;
			end else begin
				event_stall <= 1'b1;
				hold_left = pick_gap() - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && event_valid && !event_stall) begin
			tracker.check_event(event_item);
		end
	end

	initial begin
		#4000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int unsigned wait_cycles;
		tracker      = new();
		tx_gaps      = 1'b1;
		rx_quiet     = 1'b0;
		hold_request = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Each punctuation token, a string with the byte extremes, a number, true,
		// whitespace that is not skipped, a broken keyword and each way to end a stream.
		add_text("{}[]:,");
		add_byte(CH_QUOTE);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(CH_QUOTE);
		add_text("-9.");
		add_byte(8'h09);
		add_text(" \n");
		add_byte(8'h0D);
		add_text("true");
		add_text("nx");
		add_end(8'hFF);
		add_text("5");
		add_end(8'h00);
		add_byte(CH_QUOTE);
		add_end(8'h5A);
		add_text("f");
		add_end(8'h00);
		send_plan();
		drain();

		// The receiver holds off while items keep coming, so the block
		// backs up and stalls its input.
		tx_gaps      = 1'b0;
		hold_request = 240;
		while (byte_plan.size() < 80) add_token();
		send_plan();
		drain();

		for (int seg = 0; seg < 12; seg++) begin
			tx_gaps  = ($urandom_range(0, 3) != 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			while (byte_plan.size() < 150) add_token();
			send_plan();
			if (seg % 4 == 3) begin
				drain();
			end
		end

		byte_valid <= 1'b0;
		wait_cycles = 0;
		do begin
			@(posedge clk);
			wait_cycles++;
		end while (tracker.expected_events.size() != 0 && wait_cycles < 20000);
		repeat (8) @(posedge clk);
		tracker.close_out();
		if (tracker.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
